/* hw/rtl/hlsc_pkg.sv */
// Shared types and constants for the heater load shed controller.
// Holds the configuration record, datapath command struct, reason codes and field widths.
// No dependencies.
package hlsc_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_LINK_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_BAT_LIMIT    = 3'd1;
    localparam logic [2:0] REG_INV_LIMIT    = 3'd2;
    localparam logic [2:0] REG_HEATER_W     = 3'd3;
    localparam logic [2:0] REG_WARMUP       = 3'd4;
    localparam logic [2:0] REG_DRIVE_HIGH   = 3'd5;

    // Reason codes
    localparam logic [2:0] RSN_INIT     = 3'd0;
    localparam logic [2:0] RSN_CMD_ON   = 3'd1;
    localparam logic [2:0] RSN_CMD_OFF  = 3'd2;
    localparam logic [2:0] RSN_BATTERY  = 3'd3;
    localparam logic [2:0] RSN_SAFETY   = 3'd4;
    localparam logic [2:0] RSN_WARMUP   = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_LINK_TIMEOUT = 16'd30;
    localparam logic [13:0] RST_BAT_LIMIT    = 14'd0;
    localparam logic [15:0] RST_INV_LIMIT    = 16'd0;
    localparam logic [15:0] RST_HEATER_W     = 16'd1150;
    localparam logic [15:0] RST_WARMUP       = 16'd180;

    // Fixed arithmetic constants
    localparam logic [9:0]  MS_PER_S       = 10'd1000;
    localparam logic [13:0] MIN_CENTIVOLTS = 14'd100;
    localparam logic [13:0] DEF_CENTIVOLTS = 14'd2500;
    localparam logic [12:0] POWER_SCALE    = 13'd5000;

    // Stream payload widths
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic [15:0] link_timeout_s;
        logic [13:0] bat_limit_da;
        logic [15:0] inv_limit_w;
        logic [15:0] heater_w;
        logic [15:0] warmup_len_s;
        logic        drive_high;
    } t_cfg;

    // One-hot step strobes from the controller to the datapath
    typedef struct packed {
        logic load;    // capture an input transfer
        logic prep;    // sums, powers, time differences
        logic mult;    // headroom products and time compares
        logic cmp;     // headroom pass/fail
        logic commit;  // update state and load the result register
    } t_dp_cmd;

endpackage

/* hw/rtl/hlsc_cfg.sv */
// Configuration register file of the heater load shed controller.
// Depends on hlsc_pkg for register indexes, reset values and the t_cfg record.
module hlsc_cfg import hlsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Write the addressed register, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_timeout_s <= RST_LINK_TIMEOUT;
            r_cfg.bat_limit_da   <= RST_BAT_LIMIT;
            r_cfg.inv_limit_w    <= RST_INV_LIMIT;
            r_cfg.heater_w       <= RST_HEATER_W;
            r_cfg.warmup_len_s   <= RST_WARMUP;
            r_cfg.drive_high     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LINK_TIMEOUT: r_cfg.link_timeout_s <= i_cfg_data;
                REG_BAT_LIMIT:    r_cfg.bat_limit_da   <= i_cfg_data[13:0];
                REG_INV_LIMIT:    r_cfg.inv_limit_w    <= i_cfg_data;
                REG_HEATER_W:     r_cfg.heater_w       <= i_cfg_data;
                REG_WARMUP:       r_cfg.warmup_len_s   <= i_cfg_data;
                REG_DRIVE_HIGH:   r_cfg.drive_high     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/hlsc_ctrl.sv */
// Sequencer of the heater load shed controller: steps one tick through the datapath.
// Owns the input ready and the result valid flag. Depends on hlsc_pkg.
module hlsc_ctrl import hlsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_MULT   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_load;
    logic       w_commit;

    assign w_load   = (r_state == S_IDLE) && i_in_valid;
    // Commit only when the result register is free or being drained
    assign w_commit = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);

    // Advance through the steps, hold in commit while the output is full
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_PREP;
            S_PREP:   n_state = S_MULT;
            S_MULT:   n_state = S_CMP;
            S_CMP:    n_state = S_COMMIT;
            S_COMMIT: if (w_commit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Result valid: set on commit, drop on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit)
            n_out_valid = 1'b1;
        else if (i_out_ready)
            n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load   = w_load;
    assign o_cmd.prep   = (r_state == S_PREP);
    assign o_cmd.mult   = (r_state == S_MULT);
    assign o_cmd.cmp    = (r_state == S_CMP);
    assign o_cmd.commit = w_commit;

endmodule

/* hw/rtl/hlsc_dp.sv */
// Datapath of the heater load shed controller: headroom arithmetic, heater state,
// warmup timer and the result register. Depends on hlsc_pkg.
module hlsc_dp import hlsc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  t_cfg                   i_cfg,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    // Captured input fields
    logic [31:0]        r_now;
    logic [31:0]        r_last;
    logic               r_req1;
    logic               r_req2;
    logic               r_bat_ok;
    logic [13:0]        r_cv;
    logic signed [14:0] r_cur;
    logic               r_inv_ok;
    logic [15:0]        r_va;

    // Persistent state
    logic [1:0]  r_heater_on;
    logic [2:0]  r_reason;
    logic        r_warm_run;
    logic [31:0] r_warm_begin;

    // Prep stage
    logic [17:0]        r_p_hi;
    logic [17:0]        r_p_lo;
    logic signed [18:0] r_spare;
    logic [13:0]        r_v_eff;
    logic [31:0]        r_diff_link;
    logic [31:0]        r_diff_warm;
    logic [25:0]        r_link_ms;
    logic [25:0]        r_warm_ms;

    // Multiply stage
    logic signed [33:0] r_bat_prod;
    logic [30:0]        r_need_hi;
    logic [30:0]        r_need_lo;
    logic signed [16:0] r_inv_spare;
    logic               r_timeout;
    logic               r_warm_ge;
    logic               r_warm_zero;

    // Compare stage
    logic r_ok_hi;
    logic r_ok_lo;

    logic [OUT_TDATA_W-1:0] r_out;

    logic [1:0]         w_running;
    logic signed [18:0] w_cur5;
    logic               w_bat_en;
    logic               w_inv_en;
    logic               w_bat_fail_hi;
    logic               w_bat_fail_lo;
    logic               w_inv_fail_hi;
    logic               w_inv_fail_lo;

    logic       n_any;
    logic       n_start;
    logic       n_run;
    logic       n_expired;
    logic [1:0] n_allowed;
    logic       n_t1;
    logic       n_t2;
    logic [1:0] n_heater_on;
    logic [2:0] n_reason;
    logic       n_flip;

    assign w_running = {1'b0, r_heater_on[0]} + {1'b0, r_heater_on[1]};
    assign w_cur5    = 19'(r_cur) * 19'sd5;

    // Capture the input transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now    <= i_in_data[31:0];
            r_last   <= i_in_data[63:32];
            r_req1   <= i_in_data[64];
            r_req2   <= i_in_data[65];
            r_bat_ok <= i_in_data[66];
            r_cv     <= i_in_data[80:67];
            r_cur    <= $signed(i_in_data[95:81]);
            r_inv_ok <= i_in_data[96];
            r_va     <= i_in_data[112:97];
        end
    end

    // Prep: candidate powers, battery spare current, effective voltage, time deltas
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_p_hi      <= 18'(i_cfg.heater_w * ({1'b0, w_running} + 3'd1));
            r_p_lo      <= 18'(i_cfg.heater_w * w_running);
            r_spare     <= $signed({3'b000, i_cfg.bat_limit_da, 2'b00}) - w_cur5;
            r_v_eff     <= (r_cv < MIN_CENTIVOLTS) ? DEF_CENTIVOLTS : r_cv;
            r_diff_link <= r_now - r_last;
            r_diff_warm <= r_now - r_warm_begin;
            r_link_ms   <= 26'(i_cfg.link_timeout_s * MS_PER_S);
            r_warm_ms   <= 26'(i_cfg.warmup_len_s * MS_PER_S);
        end
    end

    // Multiply: battery headroom products, inverter spare, time compares
    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_bat_prod  <= 34'(r_spare) * $signed({20'd0, r_v_eff});
            r_need_hi   <= 31'(r_p_hi * POWER_SCALE);
            r_need_lo   <= 31'(r_p_lo * POWER_SCALE);
            r_inv_spare <= $signed({1'b0, i_cfg.inv_limit_w}) - $signed({1'b0, r_va});
            r_timeout   <= r_diff_link > {6'd0, r_link_ms};
            r_warm_ge   <= r_diff_warm >= {6'd0, r_warm_ms};
            r_warm_zero <= (r_warm_ms == 26'd0);
        end
    end

    assign w_bat_en      = r_bat_ok && (i_cfg.bat_limit_da != 14'd0);
    assign w_inv_en      = r_inv_ok && (i_cfg.inv_limit_w != 16'd0);
    assign w_bat_fail_hi = r_bat_prod < $signed({3'b000, r_need_hi});
    assign w_bat_fail_lo = r_bat_prod < $signed({3'b000, r_need_lo});
    assign w_inv_fail_hi = 19'(r_inv_spare) < $signed({1'b0, r_p_hi});
    assign w_inv_fail_lo = 19'(r_inv_spare) < $signed({1'b0, r_p_lo});

    // Compare: pass/fail for one more heater and for the running count
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_ok_hi <= !(w_bat_en && w_bat_fail_hi) && !(w_inv_en && w_inv_fail_hi);
            r_ok_lo <= !(w_bat_en && w_bat_fail_lo) && !(w_inv_en && w_inv_fail_lo);
        end
    end

    // Decide heater grants, warmup and reason
    always_comb begin
        n_any     = r_req1 || r_req2;
        n_start   = n_any && !r_warm_run && (r_heater_on == 2'b00);
        n_expired = n_start ? r_warm_zero : r_warm_ge;
        n_run     = (n_start || r_warm_run) && n_any && !n_expired;

        priority if (r_ok_hi)
            n_allowed = w_running + 2'd1;
        else if ((w_running != 2'd0) && r_ok_lo)
            n_allowed = w_running;
        else
            n_allowed = 2'd0;

        n_t1 = r_req1 && (n_allowed >= 2'd1);
        n_t2 = r_req2 && (n_allowed >= 2'd2);

        priority if (n_run) begin
            n_t1     = r_req1;
            n_t2     = r_req2;
            n_reason = RSN_WARMUP;
        end else if (r_req1 && !n_t1) begin
            n_reason = RSN_BATTERY;
        end else if (r_req2 && !n_t2 && n_t1) begin
            n_reason = RSN_BATTERY;
        end else if (n_t1 || n_t2) begin
            n_reason = RSN_CMD_ON;
        end else begin
            n_reason = RSN_CMD_OFF;
        end

        n_heater_on = {n_t2, n_t1};
        if (r_timeout) begin
            n_heater_on = 2'b11;
            n_reason    = RSN_SAFETY;
        end
        n_flip = !i_cfg.drive_high;
    end

    // Commit state; warmup is left alone on link timeout
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heater_on  <= 2'b11;
            r_reason     <= RSN_INIT;
            r_warm_run   <= 1'b0;
            r_warm_begin <= 32'd0;
        end else if (i_cmd.commit) begin
            r_heater_on <= n_heater_on;
            r_reason    <= n_reason;
            if (!r_timeout) begin
                r_warm_run <= n_run;
                if (n_start)
                    r_warm_begin <= r_now;
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= {1'b0, n_reason,
                      !n_heater_on[1] ^ n_flip, !n_heater_on[0] ^ n_flip,
                      n_heater_on[1], n_heater_on[0]};
        end
    end

    assign o_out_data = r_out;

endmodule

/* hw/rtl/heater_load_shed_controller.sv */
// Heater load shed controller: one result per control tick.
// Steps: capture on input transfer, then prep, multiply, compare, and commit into the
// result register. The single stepping sequencer takes no new tick until the current
// one commits, and commit waits while the result register is not drained.
// Reset (i_rst_n low, synchronous): registers to defaults, both heaters on, reason init.
// Depends on hlsc_pkg, hlsc_cfg, hlsc_ctrl, hlsc_dp.
module heater_load_shed_controller import hlsc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Input ticks
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] now_ms, [63:32] last_msg_ms, [64] request_one, [65] request_two,
    // [66] battery_valid, [80:67] battery_centivolts, [95:81] discharge_deciamps,
    // [96] inverter_valid, [112:97] inverter_va, [119:113] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] heat_one, [1] heat_two, [2] drive_one, [3] drive_two, [6:4] reason_code, [7] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;

    hlsc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    hlsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    hlsc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg      (w_cfg),
        .i_in_data  (s_axis_tdata),
        .o_out_data (m_axis_tdata)
    );

endmodule

/* hw/rtl/hlsc_chk.sv */
// Port-level checker for the heater load shed controller, bound to the top level.
// Depends on hlsc_pkg for widths and reason codes.
module hlsc_chk import hlsc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One tick at a time: no back-to-back input transfers
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a tick is in work");

    // Safety forces both heaters on, commanded off leaves both off, reason init never shows
    a_reason_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[6:4] != RSN_SAFETY || m_axis_tdata[1:0] == 2'b11) &&
            (m_axis_tdata[6:4] != RSN_CMD_OFF || m_axis_tdata[1:0] == 2'b00) &&
            (m_axis_tdata[6:4] != RSN_INIT))
        else $error("reason code inconsistent with heater state");

    // Both drive pins use the same polarity
    a_drive_polarity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[2] ^ m_axis_tdata[0]) == (m_axis_tdata[3] ^ m_axis_tdata[1]))
        else $error("drive polarity differs between relays");

endmodule

bind heater_load_shed_controller hlsc_chk u_hlsc_chk (.*);

/* bench/heater_load_shed_controller_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for heater_load_shed_controller: directed and random control ticks.
// Predicts each result in-bench and compares every output transfer field by field.
// Depends on hlsc_pkg and the controller RTL.
module heater_load_shed_controller_tb;
    import hlsc_pkg::*;

    // Indexes past the last register; writes there must be ignored
    localparam logic [2:0] REG_NONE_6 = 3'd6;
    localparam logic [2:0] REG_NONE_7 = 3'd7;

    localparam longint LOW_CENTIVOLTS  = 100;
    localparam longint SUBST_CENTIVOLTS = 2500;
    localparam longint WATT_SCALE      = 5000;

    localparam int PHASE_TICKS  = 105;
    localparam int PHASES       = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int STUCK_LIMIT  = 1000;

    // Input tick, laid out exactly as s_axis_tdata (last member in the lowest bits)
    typedef struct packed {
        logic [6:0]  pad;
        logic [15:0] va;
        logic        inv_valid;
        logic [14:0] discharge;
        logic [13:0] centivolts;
        logic        bat_valid;
        logic        req_two;
        logic        req_one;
        logic [31:0] last_ms;
        logic [31:0] now_ms;
    } t_tick;

    // Result, laid out as m_axis_tdata
    typedef struct packed {
        logic       pad;
        logic [2:0] reason;
        logic       drive_two;
        logic       drive_one;
        logic       heat_two;
        logic       heat_one;
    } t_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    heater_load_shed_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predicted controller state and register copy
    t_cfg        shed_cfg;
    logic [1:0]  heat_on;
    logic [2:0]  reason_now;
    logic        warm_active;
    logic [31:0] warm_start_ms;

    t_tick   ticks_to_send[$];
    t_result expected_results[$];
    t_tick   offered_tick;
    bit      tick_offered = 1'b0;
    int      send_gap = 0;
    int      stall_left = 0;
    int      hold_asked = 0;
    int      hold_done = 0;
    bit      quiet = 1'b0;
    int      mismatches = 0;
    int      stuck_cycles = 0;
    logic [31:0] sim_ms;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Headroom check for a total heater power in watts
    function automatic bit room_for(longint pwr, t_tick t);
        longint volts, amps, spare, inv_lim, load_va;
        volts = t.centivolts;
        amps = $signed(t.discharge);
        if (t.bat_valid && shed_cfg.bat_limit_da != 0) begin
            if (volts < LOW_CENTIVOLTS)
                volts = SUBST_CENTIVOLTS;
            spare = 4 * longint'(shed_cfg.bat_limit_da) - 5 * amps;
            if (spare * volts < WATT_SCALE * pwr)
                return 1'b0;
        end
        if (t.inv_valid && shed_cfg.inv_limit_w != 0) begin
            inv_lim = shed_cfg.inv_limit_w;
            load_va = t.va;
            if (inv_lim - load_va < pwr)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the predicted state by one tick and return the expected result
    function automatic t_result shed_decide(t_tick t);
        t_result     r;
        logic [31:0] silent_ms, warm_ms, limit_ms;
        logic        any_req, grant_one, grant_two;
        int          running, allowed;
        longint      w;
        silent_ms = t.now_ms - t.last_ms;
        limit_ms = 32'(shed_cfg.link_timeout_s) * 32'd1000;
        w = shed_cfg.heater_w;
        if (silent_ms > limit_ms) begin
            // link lost: force both on, leave warmup alone
            heat_on = 2'b11;
            reason_now = RSN_SAFETY;
        end else begin
            any_req = t.req_one | t.req_two;
            if (any_req && !warm_active && heat_on == 2'b00) begin
                warm_start_ms = t.now_ms;
                warm_active = 1'b1;
            end
            if (!any_req)
                warm_active = 1'b0;
            warm_ms = t.now_ms - warm_start_ms;
            if (warm_active && warm_ms >= 32'(shed_cfg.warmup_len_s) * 32'd1000)
                warm_active = 1'b0;

            running = int'(heat_on[0]) + int'(heat_on[1]);
            if (room_for(longint'(running + 1) * w, t))
                allowed = running + 1;
            else if (running > 0 && room_for(longint'(running) * w, t))
                allowed = running;
            else
                allowed = 0;

            grant_one = t.req_one && allowed >= 1;
            grant_two = t.req_two && allowed >= 2;
            if (warm_active) begin
                grant_one = t.req_one;
                grant_two = t.req_two;
                reason_now = RSN_WARMUP;
            end else if (t.req_one && !grant_one) begin
                reason_now = RSN_BATTERY;
            end else if (t.req_two && !grant_two && grant_one) begin
                reason_now = RSN_BATTERY;
            end else if (grant_one || grant_two) begin
                reason_now = RSN_CMD_ON;
            end else begin
                reason_now = RSN_CMD_OFF;
            end
            heat_on = {grant_two, grant_one};
        end
        r = '0;
        r.heat_one = heat_on[0];
        r.heat_two = heat_on[1];
        // coil energized while not heating, pin inverted for active-low relays
        r.drive_one = ~heat_on[0] ^ ~shed_cfg.drive_high;
        r.drive_two = ~heat_on[1] ^ ~shed_cfg.drive_high;
        r.reason = reason_now;
        return r;
    endfunction

    function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Queue one tick given field by field
    task automatic add_tick(input logic [31:0] now, input logic [31:0] last,
                            input logic [1:0] req, input logic bv, input int cv,
                            input int amps, input logic iv, input int va);
        t_tick t;
        t = '0;
        t.now_ms = now;
        t.last_ms = last;
        t.req_one = req[0];
        t.req_two = req[1];
        t.bat_valid = bv;
        t.centivolts = cv[13:0];
        t.discharge = amps[14:0];
        t.inv_valid = iv;
        t.va = va[15:0];
        ticks_to_send.push_back(t);
    endtask

    // Random tick around the running clock, mostly inside the link timeout
    function automatic t_tick random_tick();
        t_tick       t;
        int unsigned span, pick, amps;
        t = '0;
        span = 32'(shed_cfg.link_timeout_s) * 32'd1000;
        pick = $urandom_range(0, 99);
        sim_ms = sim_ms + ((pick < 5) ? $urandom() : $urandom_range(0, 2500));
        t.now_ms = sim_ms;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            t.last_ms = $urandom();
        else if (pick < 16)
            t.last_ms = sim_ms - span + 1 - $urandom_range(0, 2);
        else
            t.last_ms = sim_ms - $urandom_range(0, (span < 2000) ? span : 2000);
        pick = $urandom_range(0, 99);
        {t.req_two, t.req_one} = (pick < 20) ? 2'b00 : 2'($urandom_range(1, 3));
        t.bat_valid = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 65)
            t.centivolts = 14'($urandom_range(4400, 5800));
        else if (pick < 80)
            t.centivolts = 14'($urandom_range(0, 120));
        else
            t.centivolts = 14'($urandom_range(0, 16383));
        amps = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 6000) - 2000
                                              : $urandom_range(0, 32767);
        t.discharge = amps[14:0];
        t.inv_valid = ($urandom_range(0, 9) != 0);
        t.va = 16'(($urandom_range(0, 99) < 70) ? $urandom_range(0, shed_cfg.inv_limit_w)
                                                 : $urandom_range(0, 65535));
        return t;
    endfunction

    // Single register write, mirrored into the predicted register copy
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            REG_LINK_TIMEOUT: shed_cfg.link_timeout_s = val;
            REG_BAT_LIMIT:    shed_cfg.bat_limit_da = val[13:0];
            REG_INV_LIMIT:    shed_cfg.inv_limit_w = val;
            REG_HEATER_W:     shed_cfg.heater_w = val;
            REG_WARMUP:       shed_cfg.warmup_len_s = val;
            REG_DRIVE_HIGH:   shed_cfg.drive_high = val[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] link, input logic [15:0] bat,
                                 input logic [15:0] inv, input logic [15:0] heater,
                                 input logic [15:0] warm, input logic [15:0] drive);
        write_reg(REG_LINK_TIMEOUT, link);
        write_reg(REG_BAT_LIMIT, bat);
        write_reg(REG_INV_LIMIT, inv);
        write_reg(REG_HEATER_W, heater);
        write_reg(REG_WARMUP, warm);
        write_reg(REG_DRIVE_HIGH, drive);
    endtask

    // Wait until every queued tick has produced its result
    task automatic settle();
        while (ticks_to_send.size() != 0 || tick_offered || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Tick sender: offer the next queued tick, hold it until the transfer
    always @(negedge i_clk) begin
        if (!tick_offered) begin
            if (send_gap == 0 && ticks_to_send.size() != 0) begin
                offered_tick = ticks_to_send.pop_front();
                tick_offered = 1'b1;
                s_axis_tdata <= offered_tick;
                s_axis_tvalid <= 1'b1;
            end else begin
                if (send_gap > 0)
                    send_gap--;
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts plus requested long hold-offs
    always @(negedge i_clk) begin
        if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) < 3) begin
            stall_left = $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predict on input transfers, check output transfers, watch for a hang
    always @(posedge i_clk) begin : monitor
        t_result got, want;
        bit      in_xfer, out_xfer;
        in_xfer = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_xfer = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (out_xfer) begin
            got = m_axis_tdata;
            if (expected_results.size() == 0) begin
                $display("%0t: result transfer with none expected, actual %h", $time, got);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("heat_one", 3'(want.heat_one), 3'(got.heat_one));
                check_field("heat_two", 3'(want.heat_two), 3'(got.heat_two));
                check_field("drive_one", 3'(want.drive_one), 3'(got.drive_one));
                check_field("drive_two", 3'(want.drive_two), 3'(got.drive_two));
                check_field("reason_code", want.reason, got.reason);
            end
        end
        if (in_xfer) begin
            expected_results.push_back(shed_decide(offered_tick));
            tick_offered = 1'b0;
            if (!quiet && $urandom_range(0, 9) < 3)
                send_gap = $urandom_range(1, 5);
        end
        if (in_xfer || out_xfer || (ticks_to_send.size() == 0 && !tick_offered &&
                                    expected_results.size() == 0))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
            $display("heater_load_shed_controller_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int ph, n;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        shed_cfg.link_timeout_s = RST_LINK_TIMEOUT;
        shed_cfg.bat_limit_da = RST_BAT_LIMIT;
        shed_cfg.inv_limit_w = RST_INV_LIMIT;
        shed_cfg.heater_w = RST_HEATER_W;
        shed_cfg.warmup_len_s = RST_WARMUP;
        shed_cfg.drive_high = 1'b1;
        heat_on = 2'b11;
        reason_now = RSN_INIT;
        warm_active = 1'b0;
        warm_start_ms = '0;
        sim_ms = $urandom();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: timeout edge, wrapped silence, warmup start and end
        add_tick(32'd1000, 32'd1000, 2'b11, 1'b0, 0, 0, 1'b0, 0);
        add_tick(32'd31000, 32'd1000, 2'b00, 1'b0, 0, 0, 1'b0, 0);
        add_tick(32'd31001, 32'd1000, 2'b00, 1'b0, 0, 0, 1'b0, 0);
        add_tick(32'd0, 32'd1, 2'b11, 1'b0, 0, 0, 1'b0, 0);
        add_tick(32'd5, 32'hFFFF_FFF0, 2'b00, 1'b0, 0, 0, 1'b0, 0);
        add_tick(32'd100000, 32'd100000, 2'b01, 1'b0, 0, 0, 1'b0, 0);
        add_tick(32'd279999, 32'd279999, 2'b11, 1'b1, 16383, 16383, 1'b1, 65535);
        add_tick(32'd280000, 32'd280000, 2'b11, 1'b1, 16383, -16384, 1'b1, 65535);
        settle();

        // Zero timeout, both limits on, exact headroom edges, low-voltage substitute
        load_settings(16'd0, 16'd1000, 16'd5000, 16'd1000, 16'd0, 16'h0002);
        write_reg(REG_NONE_6, 16'hFFFF);
        write_reg(REG_NONE_7, 16'h1234);
        add_tick(32'd500, 32'd500, 2'b00, 1'b1, 5000, 0, 1'b0, 0);
        add_tick(32'd500, 32'd499, 2'b11, 1'b1, 5000, 0, 1'b0, 0);
        add_tick(32'd600, 32'd600, 2'b11, 1'b1, 99, 0, 1'b0, 0);
        add_tick(32'd600, 32'd600, 2'b11, 1'b1, 100, 0, 1'b0, 0);
        add_tick(32'd700, 32'd700, 2'b11, 1'b1, 100, 0, 1'b0, 0);
        add_tick(32'd800, 32'd800, 2'b11, 1'b0, 0, 0, 1'b1, 3000);
        add_tick(32'd900, 32'd900, 2'b11, 1'b0, 0, 0, 1'b1, 3000);
        add_tick(32'd1000, 32'd1000, 2'b11, 1'b0, 0, 0, 1'b1, 3001);
        add_tick(32'd1100, 32'd1100, 2'b10, 1'b0, 0, 0, 1'b1, 0);
        add_tick(32'd1200, 32'd1200, 2'b11, 1'b1, 16383, -16384, 1'b1, 65535);
        add_tick(32'd1300, 32'd1300, 2'b11, 1'b1, 16383, 16383, 1'b0, 0);
        add_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b01, 1'b1, 10000, -10000, 1'b1, 0);
        settle();

        // Random phases, each under its own register settings
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                default: load_settings(
                    16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(1, 90)),
                    16'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(300, 2500)),
                    16'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1500, 9000)),
                    16'($urandom_range(300, 3000)),
                    16'($urandom_range(0, 6)),
                    16'($urandom_range(0, 1)));
            endcase
            // long receiver hold-off so the block backs up into the sender
            if (ph == 2)
                hold_asked++;
            // no idling in the closing phase
            if (ph == PHASES - 1)
                quiet = 1'b1;
            for (n = 0; n < PHASE_TICKS; n++)
                ticks_to_send.push_back(random_tick());
            settle();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("heater_load_shed_controller_tb OK");
        else
            $display("heater_load_shed_controller_tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/hlsc_pkg.sv
hw/rtl/hlsc_cfg.sv
hw/rtl/hlsc_ctrl.sv
hw/rtl/hlsc_dp.sv
hw/rtl/heater_load_shed_controller.sv
hw/rtl/hlsc_chk.sv
bench/heater_load_shed_controller_tb.sv
